// ===== rtl/core/pnorm_pkg.sv =====
`timescale 1ns / 1ps

package pnorm_pkg;

    // Buffer sizes of the source and result stores.
    localparam int IN_CAPACITY  = 256;
    localparam int OUT_CAPACITY = 256;

    localparam int BYTE_W = 8;
    localparam int NLEN_W = 9;

    localparam int SRC_AW = $clog2(IN_CAPACITY);
    localparam int SRC_CW = $clog2(IN_CAPACITY + 1);
    localparam int RES_AW = $clog2(OUT_CAPACITY);
    localparam int RES_CW = $clog2(OUT_CAPACITY + 1);

    // The normalized path is capped at one byte below the result store size.
    localparam logic [RES_CW-1:0] RES_LIMIT = RES_CW'(OUT_CAPACITY - 1);

    // Item function codes.
    localparam logic [1:0] FUNC_APPEND = 2'd0;
    localparam logic [1:0] FUNC_NORM   = 2'd1;
    localparam logic [1:0] FUNC_FETCH  = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // Characters the normalizer looks for.
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_BACK  = 8'h5C;

    typedef struct packed {
        logic [1:0]        func;
        logic [BYTE_W-1:0] path_byte;
    } pnorm_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic              out_last;
        logic [NLEN_W-1:0] norm_length;
        logic              dropped;
    } pnorm_out_t;

    typedef struct packed {
        logic              start;
        logic [SRC_CW-1:0] src_count;
    } pnorm_seq_req_t;

    typedef struct packed {
        logic              done;
        logic [RES_CW-1:0] length;
    } pnorm_seq_rsp_t;

    typedef struct packed {
        logic [SRC_AW-1:0] src_raddr;
        logic              res_we;
        logic [RES_AW-1:0] res_waddr;
        logic [BYTE_W-1:0] res_wdata;
        logic [RES_AW-1:0] res_raddr;
    } pnorm_mem_req_t;

endpackage

// ===== rtl/core/pnorm_ram.sv =====
`timescale 1ns / 1ps

module pnorm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pnorm_seq.sv =====
`timescale 1ns / 1ps

module pnorm_seq (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pnorm_pkg::pnorm_seq_req_t        req,
    output pnorm_pkg::pnorm_seq_rsp_t        rsp,
    output pnorm_pkg::pnorm_mem_req_t        mem,
    input  logic [pnorm_pkg::BYTE_W-1:0]     src_q,
    input  logic [pnorm_pkg::BYTE_W-1:0]     res_q
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_ISSUE     = 9'b000000010,
        S_C0        = 9'b000000100,
        S_C1        = 9'b000001000,
        S_C2        = 9'b000010000,
        S_C3        = 9'b000100000,
        S_POP_ISSUE = 9'b001000000,
        S_POP_CHK   = 9'b010000000,
        S_TRAIL     = 9'b100000000
    } seq_state_t;

    seq_state_t                        state_reg, state_next;
    logic [pnorm_pkg::SRC_CW-1:0]      pos_reg, pos_next;
    logic [pnorm_pkg::SRC_CW-1:0]      n_reg, n_next;
    logic [pnorm_pkg::RES_CW-1:0]      len_reg, len_next;
    logic                              last_slash_reg, last_slash_next;
    logic                              first_slash_reg, first_slash_next;

    logic [pnorm_pkg::SRC_CW:0]        pos_p1, pos_p2, pos_p3, n_ext;
    logic [pnorm_pkg::RES_CW-1:0]      len_m1;
    logic [pnorm_pkg::BYTE_W-1:0]      c0, emit_byte;
    logic                              q_sep, emit, dotdot;

    assign pos_p1 = {1'b0, pos_reg} + 1'b1;
    assign pos_p2 = {1'b0, pos_reg} + 2'd2;
    assign pos_p3 = {1'b0, pos_reg} + 2'd3;
    assign n_ext  = {1'b0, n_reg};
    assign len_m1 = len_reg - 1'b1;
    assign c0     = (src_q == pnorm_pkg::CH_BACK) ? pnorm_pkg::CH_SLASH : src_q;
    assign q_sep  = (src_q == pnorm_pkg::CH_SLASH) || (src_q == pnorm_pkg::CH_BACK);

    always_comb begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        n_next           = n_reg;
        len_next         = len_reg;
        last_slash_next  = last_slash_reg;
        first_slash_next = first_slash_reg;
        emit             = 1'b0;
        emit_byte        = pnorm_pkg::CH_SLASH;
        dotdot           = 1'b0;
        rsp              = '0;
        mem.src_raddr    = pos_reg[pnorm_pkg::SRC_AW-1:0];
        mem.res_we       = 1'b0;
        mem.res_waddr    = len_reg[pnorm_pkg::RES_AW-1:0];
        mem.res_wdata    = pnorm_pkg::CH_SLASH;
        mem.res_raddr    = len_m1[pnorm_pkg::RES_AW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (req.start) begin
                    n_next          = req.src_count;
                    pos_next        = '0;
                    len_next        = '0;
                    last_slash_next = 1'b0;
                    state_next      = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (pos_reg >= n_reg || len_reg >= pnorm_pkg::RES_LIMIT) begin
                    state_next = S_TRAIL;
                end else begin
                    state_next = S_C0;
                end
            end
            S_C0: begin
                mem.src_raddr = pos_p1[pnorm_pkg::SRC_AW-1:0];
                emit_byte     = c0;
                if (c0 == pnorm_pkg::CH_SLASH) begin
                    if (last_slash_reg) begin
                        pos_next   = pos_p1[pnorm_pkg::SRC_CW-1:0];
                        state_next = S_ISSUE;
                    end else if (pos_p1 < n_ext) begin
                        state_next = S_C1;
                    end else begin
                        emit = 1'b1;
                    end
                end else begin
                    emit = 1'b1;
                end
            end
            S_C1: begin
                mem.src_raddr = pos_p2[pnorm_pkg::SRC_AW-1:0];
                if (src_q == pnorm_pkg::CH_DOT) begin
                    if (pos_p2 >= n_ext) begin
                        pos_next   = pos_p2[pnorm_pkg::SRC_CW-1:0];
                        state_next = S_ISSUE;
                    end else begin
                        state_next = S_C2;
                    end
                end else begin
                    emit = 1'b1;
                end
            end
            S_C2: begin
                mem.src_raddr = pos_p3[pnorm_pkg::SRC_AW-1:0];
                if (q_sep) begin
                    pos_next   = pos_p2[pnorm_pkg::SRC_CW-1:0];
                    state_next = S_ISSUE;
                end else if (src_q == pnorm_pkg::CH_DOT) begin
                    if (pos_p3 >= n_ext) begin
                        dotdot = 1'b1;
                    end else begin
                        state_next = S_C3;
                    end
                end else begin
                    emit = 1'b1;
                end
            end
            S_C3: begin
                if (q_sep) begin
                    dotdot = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end
            S_POP_ISSUE: begin
                // Walk back through the result until a slash or the first byte.
                if (len_reg > 1) begin
                    state_next = S_POP_CHK;
                end else begin
                    last_slash_next = first_slash_reg;
                    state_next      = S_ISSUE;
                end
            end
            S_POP_CHK: begin
                if (res_q == pnorm_pkg::CH_SLASH) begin
                    last_slash_next = 1'b1;
                    state_next      = S_ISSUE;
                end else begin
                    len_next   = len_m1;
                    state_next = S_POP_ISSUE;
                end
            end
            S_TRAIL: begin
                rsp.done   = 1'b1;
                rsp.length = len_reg;
                if (len_reg > 1 && last_slash_reg) begin
                    rsp.length = len_m1;
                end else if (len_reg == '0) begin
                    mem.res_we    = 1'b1;
                    mem.res_waddr = '0;
                    mem.res_wdata = pnorm_pkg::CH_SLASH;
                    rsp.length    = pnorm_pkg::RES_CW'(1);
                end
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (emit) begin
            mem.res_we      = 1'b1;
            mem.res_waddr   = len_reg[pnorm_pkg::RES_AW-1:0];
            mem.res_wdata   = emit_byte;
            len_next        = len_reg + 1'b1;
            pos_next        = pos_p1[pnorm_pkg::SRC_CW-1:0];
            last_slash_next = (emit_byte == pnorm_pkg::CH_SLASH);
            if (len_reg == '0) begin
                first_slash_next = (emit_byte == pnorm_pkg::CH_SLASH);
            end
            state_next = S_ISSUE;
        end

        if (dotdot) begin
            pos_next = pos_p3[pnorm_pkg::SRC_CW-1:0];
            if (len_reg > 1) begin
                len_next   = len_m1;
                state_next = S_POP_ISSUE;
            end else begin
                state_next = S_ISSUE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        pos_reg         <= pos_next;
        n_reg           <= n_next;
        len_reg         <= len_next;
        last_slash_reg  <= last_slash_next;
        first_slash_reg <= first_slash_next;
    end

endmodule

// ===== rtl/core/path_normalizer_top.sv =====
`timescale 1ns / 1ps

// Path normalizer. Items carry a function code: append stores one path byte
// into a 256-byte source memory (a byte that finds it full is dropped and
// flagged), fetch returns the next normalized byte, read from the result
// memory through a registered port, and end of path runs the normalization
// pass and answers with the normalized length. That pass is one sequencer
// sharing a single read port on each memory: it steps through the source a
// byte at a time, reads ahead past a slash that may start a "." or ".."
// segment, and walks back over every result byte that a ".." pops, so the
// length of the pass grows with the length of the path.
// Backslashes count as slashes, repeated slashes collapse, the result is
// capped at one byte below the result memory size, a trailing slash goes
// away unless it is the whole path, and an empty result reads as "/".
// The block takes no new item while a pass or fetch is running. A result
// item waits in an output register, and the next item is taken as soon as
// that register is free or being drained.
module path_normalizer_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pnorm_pkg::pnorm_in_t  s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pnorm_pkg::pnorm_out_t m_item
);

    typedef enum logic [2:0] {
        T_IDLE  = 3'b001,
        T_NORM  = 3'b010,
        T_FETCH = 3'b100
    } top_state_t;

    top_state_t                       state_reg, state_next;
    logic [pnorm_pkg::SRC_CW-1:0]     src_cnt_reg, src_cnt_next;
    logic [pnorm_pkg::RES_CW-1:0]     res_cnt_reg, res_cnt_next;
    logic [pnorm_pkg::RES_CW-1:0]     rptr_reg, rptr_next;
    logic                             m_valid_reg, m_valid_next;
    pnorm_pkg::pnorm_out_t            m_item_reg, m_item_next;

    pnorm_pkg::pnorm_seq_req_t        seq_req;
    pnorm_pkg::pnorm_seq_rsp_t        seq_rsp;
    pnorm_pkg::pnorm_mem_req_t        seq_mem;

    logic                             accept, src_full, src_we, fetch_ok;
    logic [pnorm_pkg::RES_AW-1:0]     res_raddr;
    logic [pnorm_pkg::RES_CW-1:0]     rptr_p1;
    logic [pnorm_pkg::BYTE_W-1:0]     src_q, res_q;

    assign s_ready  = (state_reg == T_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign src_full = (src_cnt_reg >= pnorm_pkg::SRC_CW'(pnorm_pkg::IN_CAPACITY));
    assign src_we   = accept && (s_item.func == pnorm_pkg::FUNC_APPEND) && !src_full;
    assign fetch_ok = (rptr_reg < res_cnt_reg);
    assign rptr_p1  = rptr_reg + 1'b1;

    // The sequencer owns the result read port during a pass; otherwise it
    // points at the next byte to fetch.
    assign res_raddr = (state_reg == T_NORM) ? seq_mem.res_raddr
                                             : rptr_reg[pnorm_pkg::RES_AW-1:0];

    assign seq_req.start     = accept && (s_item.func == pnorm_pkg::FUNC_NORM);
    assign seq_req.src_count = src_cnt_reg;

    pnorm_ram #(
        .WIDTH (pnorm_pkg::BYTE_W),
        .DEPTH (pnorm_pkg::IN_CAPACITY)
    ) u_src_ram (
        .aclk  (aclk),
        .we    (src_we),
        .waddr (src_cnt_reg[pnorm_pkg::SRC_AW-1:0]),
        .wdata (s_item.path_byte),
        .raddr (seq_mem.src_raddr),
        .rdata (src_q)
    );

    pnorm_ram #(
        .WIDTH (pnorm_pkg::BYTE_W),
        .DEPTH (pnorm_pkg::OUT_CAPACITY)
    ) u_res_ram (
        .aclk  (aclk),
        .we    (seq_mem.res_we),
        .waddr (seq_mem.res_waddr),
        .wdata (seq_mem.res_wdata),
        .raddr (res_raddr),
        .rdata (res_q)
    );

    pnorm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (seq_req),
        .rsp     (seq_rsp),
        .mem     (seq_mem),
        .src_q   (src_q),
        .res_q   (res_q)
    );

    always_comb begin
        state_next   = state_reg;
        src_cnt_next = src_cnt_reg;
        res_cnt_next = res_cnt_reg;
        rptr_next    = rptr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;

        case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    case (s_item.func)
                        pnorm_pkg::FUNC_APPEND: begin
                            m_item_next         = '0;
                            m_item_next.dropped = src_full;
                            m_valid_next        = 1'b1;
                            if (!src_full) begin
                                src_cnt_next = src_cnt_reg + 1'b1;
                            end
                        end
                        pnorm_pkg::FUNC_NORM: begin
                            state_next = T_NORM;
                        end
                        pnorm_pkg::FUNC_FETCH: begin
                            if (fetch_ok) begin
                                state_next = T_FETCH;
                            end else begin
                                m_item_next  = '0;
                                m_valid_next = 1'b1;
                            end
                        end
                        default: begin
                            m_item_next  = '0;
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            T_NORM: begin
                if (seq_rsp.done) begin
                    m_item_next             = '0;
                    m_item_next.norm_length = pnorm_pkg::NLEN_W'(seq_rsp.length);
                    m_valid_next            = 1'b1;
                    res_cnt_next            = seq_rsp.length;
                    rptr_next               = '0;
                    src_cnt_next            = '0;
                    state_next              = T_IDLE;
                end
            end
            T_FETCH: begin
                m_item_next           = '0;
                m_item_next.out_byte  = res_q;
                m_item_next.out_valid = 1'b1;
                m_item_next.out_last  = (rptr_p1 == res_cnt_reg);
                m_valid_next          = 1'b1;
                rptr_next             = rptr_p1;
                state_next            = T_IDLE;
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            src_cnt_reg <= '0;
            res_cnt_reg <= '0;
            rptr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            src_cnt_reg <= src_cnt_next;
            res_cnt_reg <= res_cnt_next;
            rptr_reg    <= rptr_next;
            m_valid_reg <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== bench/tb_path_normalizer_top.sv =====
`timescale 1ns / 1ps

module tb_path_normalizer_top;

    import pnorm_pkg::*;

    localparam int ITEM_TARGET  = 1100;
    localparam int MAX_WAIT     = 11;
    localparam int DRAIN_CYCLES = 64;
    localparam int TIMEOUT_NS   = 2_000_000;

    // Keeps its own copy of the source and result buffers and predicts the
    // result item that every accepted input item produces.
    class path_scoreboard;
        logic [BYTE_W-1:0] src_mem [IN_CAPACITY];
        logic [BYTE_W-1:0] res_mem [OUT_CAPACITY];
        int src_len;
        int res_len;
        int rd_ptr;
        pnorm_out_t expected_q [$];
        int errors;
        int checked;
        int paths_done;
        int drops_seen;
        int longest;

        function new();
            src_len = 0;
            res_len = 0;
            rd_ptr = 0;
            errors = 0;
            checked = 0;
            paths_done = 0;
            drops_seen = 0;
            longest = 0;
        endfunction

        function bit is_sep(logic [BYTE_W-1:0] c);
            return c == CH_SLASH || c == CH_BACK;
        endfunction

        // Canonical form of the stored path; returns its length.
        function int canonicalize();
            int pos;
            int len;
            logic [BYTE_W-1:0] c;
            pos = 0;
            len = 0;
            if (src_len == 0) begin
                res_mem[0] = CH_SLASH;
                return 1;
            end
            while (pos < src_len && len < OUT_CAPACITY - 1) begin
                c = src_mem[pos];
                if (c == CH_BACK) begin
                    c = CH_SLASH;
                end
                if (c == CH_SLASH) begin
                    if (len > 0 && res_mem[len-1] == CH_SLASH) begin
                        pos++;
                        continue;
                    end
                    if (pos + 1 < src_len && src_mem[pos+1] == CH_DOT) begin
                        // A lone "." segment vanishes together with its slash.
                        if (pos + 2 >= src_len || is_sep(src_mem[pos+2])) begin
                            pos += 2;
                            continue;
                        end
                        // A ".." segment pops back to the previous slash, but
                        // never removes the leading byte.
                        if (src_mem[pos+2] == CH_DOT &&
                            (pos + 3 >= src_len || is_sep(src_mem[pos+3]))) begin
                            if (len > 1) begin
                                len--;
                                while (len > 1 && res_mem[len-1] != CH_SLASH) begin
                                    len--;
                                end
                            end
                            pos += 3;
                            continue;
                        end
                    end
                end
                res_mem[len] = c;
                len++;
                pos++;
            end
            if (len > 1 && res_mem[len-1] == CH_SLASH) begin
                len--;
            end
            if (len == 0) begin
                res_mem[0] = CH_SLASH;
                len = 1;
            end
            return len;
        endfunction

        function void note_input(pnorm_in_t it);
            pnorm_out_t e;
            e = '0;
            case (it.func)
                FUNC_APPEND: begin
                    if (src_len < IN_CAPACITY) begin
                        src_mem[src_len] = it.path_byte;
                        src_len++;
                    end else begin
                        e.dropped = 1'b1;
                        drops_seen++;
                    end
                end
                FUNC_NORM: begin
                    res_len = canonicalize();
                    rd_ptr = 0;
                    src_len = 0;
                    e.norm_length = NLEN_W'(res_len);
                    paths_done++;
                    if (res_len > longest) begin
                        longest = res_len;
                    end
                end
                FUNC_FETCH: begin
                    if (rd_ptr < res_len && rd_ptr < OUT_CAPACITY) begin
                        e.out_byte = res_mem[rd_ptr];
                        e.out_valid = 1'b1;
                        e.out_last = (rd_ptr + 1 == res_len);
                        rd_ptr++;
                    end
                end
                default: begin
                end
            endcase
            expected_q.push_back(e);
        endfunction

        function void check_result(pnorm_out_t got);
            pnorm_out_t e;
            if (expected_q.size() == 0) begin
                $error("result item arrived with nothing expected: %p", got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.out_byte !== e.out_byte) begin
                $error("out_byte: expected %0h, got %0h", e.out_byte, got.out_byte);
                errors++;
            end
            if (got.out_valid !== e.out_valid) begin
                $error("out_valid: expected %0h, got %0h", e.out_valid, got.out_valid);
                errors++;
            end
            if (got.out_last !== e.out_last) begin
                $error("out_last: expected %0h, got %0h", e.out_last, got.out_last);
                errors++;
            end
            if (got.norm_length !== e.norm_length) begin
                $error("norm_length: expected %0h, got %0h", e.norm_length,
                       got.norm_length);
                errors++;
            end
            if (got.dropped !== e.dropped) begin
                $error("dropped: expected %0h, got %0h", e.dropped, got.dropped);
                errors++;
            end
        endfunction
    endclass

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       m_ready = 1'b0;
    pnorm_in_t  s_item  = '0;
    logic       s_ready;
    logic       m_valid;
    pnorm_out_t m_item;

    path_scoreboard sb;

    // When set, both sides run without any idle cycles.
    bit calm = 1'b0;
    int items_sent = 0;
    logic [BYTE_W-1:0] path_q [$];

    path_normalizer_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function int draw_wait();
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Both monitors read the values that were present just before the edge.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_input(s_item);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_item);
        end
    end

    // Result side: a random stall before every item, then ready until taken.
    initial begin : result_sink
        int stall;
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_valid === 1'b1));
        end
    end

    // Valid stays high into the next item when no gap is drawn, so it is
    // never lowered and raised in the same step.
    task automatic send_item(logic [1:0] f, logic [BYTE_W-1:0] b);
        pnorm_in_t it;
        int gap;
        it.func = f;
        it.path_byte = b;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        if (f != FUNC_NONE) begin
            items_sent++;
        end
    endtask

    task automatic append_path();
        foreach (path_q[i]) begin
            if ($urandom_range(0, 19) == 0) begin
                send_item(FUNC_NONE, 8'($urandom_range(0, 255)));
            end
            send_item(FUNC_APPEND, path_q[i]);
        end
    endtask

    task automatic fetch_bytes(int n);
        repeat (n) send_item(FUNC_FETCH, 8'($urandom_range(0, 255)));
    endtask

    task automatic append_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(FUNC_APPEND, s[i]);
        end
    endtask

    function automatic logic [BYTE_W-1:0] any_letter();
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    // Short path built from segments: separators of both kinds, doubled
    // separators, "." and ".." segments, look-alikes such as "..." and ".x",
    // names, and arbitrary bytes.
    function automatic void build_short_path();
        int nseg;
        path_q.delete();
        nseg = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) begin
            path_q.push_back(any_letter());
        end
        for (int s = 0; s < nseg; s++) begin
            case ($urandom_range(0, 5))
                0, 1, 2: path_q.push_back(CH_SLASH);
                3: path_q.push_back(CH_BACK);
                4: begin
                    path_q.push_back(CH_SLASH);
                    path_q.push_back(CH_SLASH);
                end
                default: begin
                    path_q.push_back(CH_SLASH);
                    path_q.push_back(CH_BACK);
                end
            endcase
            case ($urandom_range(0, 9))
                0, 1: path_q.push_back(CH_DOT);
                2, 3: begin
                    path_q.push_back(CH_DOT);
                    path_q.push_back(CH_DOT);
                end
                4: begin
                end
                5: repeat (3) path_q.push_back(CH_DOT);
                6: begin
                    path_q.push_back(CH_DOT);
                    path_q.push_back(any_letter());
                end
                7: repeat ($urandom_range(1, 3)) path_q.push_back(8'($urandom_range(0, 255)));
                default: repeat ($urandom_range(1, 4)) path_q.push_back(any_letter());
            endcase
        end
        if ($urandom_range(0, 3) == 0) begin
            path_q.push_back($urandom_range(0, 1) ? CH_SLASH : CH_BACK);
        end
    endfunction

    // Long path that can overrun the source buffer. Plain names fill the result
    // buffer to its cap; the mixed form exercises dots and pops at depth.
    function automatic void build_long_path(int n, bit mixed);
        path_q.delete();
        for (int i = 0; i < n; i++) begin
            if (mixed) begin
                case ($urandom_range(0, 7))
                    0: path_q.push_back(CH_SLASH);
                    1: path_q.push_back(CH_BACK);
                    2, 3: path_q.push_back(CH_DOT);
                    default: path_q.push_back(any_letter());
                endcase
            end else begin
                path_q.push_back($urandom_range(0, 31) == 0 ? CH_SLASH : any_letter());
            end
        end
    endfunction

    initial begin : stimulus
        int seq_no;
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: fetch with nothing normalized, the unused selector, an
        // empty path reading as "/", a fetch past the end, mixed separators
        // with "." and ".." segments, and ".." right at the start.
        send_item(FUNC_FETCH, 8'h00);
        send_item(FUNC_NONE, 8'hFF);
        send_item(FUNC_NORM, 8'h00);
        fetch_bytes(2);
        append_text("\\a//.\\b/..\\..");
        send_item(FUNC_NORM, 8'hFF);
        fetch_bytes(2);
        append_text("/..");
        send_item(FUNC_NORM, 8'h00);

        // Random part: mostly complete paths with random content, then a
        // readout; some noise, some paths left unterminated so they run into
        // the next one, and two long paths near or past the source buffer size.
        seq_no = 0;
        while (items_sent < ITEM_TARGET) begin
            calm = ($urandom_range(0, 5) == 0);
            if (seq_no == 2) begin
                build_long_path(258, 1'b0);
                append_path();
                send_item(FUNC_NORM, 8'($urandom_range(0, 255)));
                fetch_bytes(OUT_CAPACITY + 1);
            end else if (seq_no == 6) begin
                build_long_path($urandom_range(250, 270), 1'b1);
                append_path();
                send_item(FUNC_NORM, 8'($urandom_range(0, 255)));
                fetch_bytes($urandom_range(0, 8));
            end else if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
            end else begin
                build_short_path();
                append_path();
                if ($urandom_range(0, 7) != 0) begin
                    send_item(FUNC_NORM, 8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 3) != 0) begin
                    fetch_bytes(path_q.size() + 2);
                end else begin
                    fetch_bytes($urandom_range(0, path_q.size()));
                end
            end
            seq_no++;
        end
        s_valid <= 1'b0;

        // Let the monitor record the last accepted item before draining.
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d items in %0d sequences, %0d paths, %0d results checked.",
                 items_sent, seq_no, sb.paths_done, sb.checked);
        $display("Longest path %0d bytes; %0d appended bytes flagged dropped.",
                 sb.longest, sb.drops_seen);
        if (sb.errors == 0) begin
            $display("** path_normalizer_top: PASSED **");
        end else begin
            $display("** path_normalizer_top: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timeout: stimulus or results did not complete.");
        $display("** path_normalizer_top: FAILED **");
        $finish;
    end

endmodule
